/* rtl/alarm_timer_table_macros.svh */
// ----------------------------------------------------------------------------
// alarm_timer_table_macros.svh
// assertion helpers for the alarm timer table
// ----------------------------------------------------------------------------
`ifndef ALARM_TIMER_TABLE_MACROS_SVH
`define ALARM_TIMER_TABLE_MACROS_SVH

// same-cycle implication, disabled in reset
`define ATT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("alarm timer table assertion failed");

// next-cycle implication, disabled in reset
`define ATT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("alarm timer table assertion failed");

`endif

/* rtl/att_pkg.sv */
// ----------------------------------------------------------------------------
// att_pkg
// shared types and constants of the alarm timer table
// ----------------------------------------------------------------------------
package att_pkg;

   localparam int ALARM_SLOTS = 8;
   localparam int SLOT_IDX_W  = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
   localparam int ID_W        = 8;
   localparam int DELAY_W     = 23;

   localparam logic CMD_PROGRAM = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   typedef struct packed {
      logic               command;
      logic [ID_W-1:0]    msg_id;
      logic               periodic;
      logic [DELAY_W-1:0] delay;
   } req_word_type;

   typedef struct packed {
      logic [ID_W-1:0] fired_id;
      logic            last_fired;
   } rsp_word_type;

endpackage

/* rtl/alarm_timer_table.sv */
// ----------------------------------------------------------------------------
// alarm_timer_table
// table of countdown alarm slots with program, cancel and tick commands
// ----------------------------------------------------------------------------
// Each command word is registered and then walked over the slot table one slot
// per cycle (during a tick, only while a held expiry can move on) through a
// single compare/decrement unit, followed by a closing state (insert into the
// first free slot, or flush of the final expiry); the next word is taken only
// once the sequencer is back in idle. A tick scan stalls while the result channel
// stalls: an expiry is held one expiry behind so that the final one carries
// last_fired, and the scan waits whenever a held expiry cannot move into the
// output register. A program command yields no result word.
`include "alarm_timer_table_macros.svh"

module alarm_timer_table
   import att_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROG_SCAN,
      S_INSERT,
      S_TICK_SCAN,
      S_FLUSH
   } state_type;

   localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(ALARM_SLOTS - 1);

   state_type              state_ff;
   req_word_type           req_ff;
   logic [SLOT_IDX_W-1:0]  scan_idx_ff;
   logic [SLOT_IDX_W-1:0]  free_idx_ff;
   logic                   free_found_ff;
   logic                   matched_ff;
   logic                   pend_valid_ff;
   logic [ID_W-1:0]        pend_id_ff;
   logic                   rsp_valid_ff;
   rsp_word_type           rsp_word_ff;

   logic [ALARM_SLOTS-1:0] slot_active_ff;
   logic [ID_W-1:0]        slot_id_ff     [ALARM_SLOTS];
   logic                   slot_repeats_ff[ALARM_SLOTS];
   logic [DELAY_W-1:0]     slot_period_ff [ALARM_SLOTS];
   logic [DELAY_W-1:0]     slot_count_ff  [ALARM_SLOTS];

   logic                   cur_active;
   logic [DELAY_W-1:0]     cur_count;
   logic                   cur_gt1;
   logic                   cur_fire;
   logic                   cur_match;
   logic                   delay_zero;
   logic                   out_free;
   logic                   scan_advance;
   logic                   rsp_load;
   logic                   do_insert;
   logic                   wr_cfg;
   logic                   wr_cnt;
   logic [SLOT_IDX_W-1:0]  wr_idx;
   logic [DELAY_W-1:0]     wr_cnt_val;
   logic                   prog_busy;
   logic                   flush_exit;

   // shared slot unit: one slot read, compared and decremented per cycle while the scan is not held
   always_comb begin
      cur_active   = slot_active_ff[scan_idx_ff];
      cur_count    = slot_count_ff[scan_idx_ff];
      cur_gt1      = cur_count > DELAY_W'(1);
      cur_fire     = cur_active && !cur_gt1;
      cur_match    = cur_active && (slot_id_ff[scan_idx_ff] == req_ff.msg_id);
      delay_zero   = req_ff.delay == '0;
      out_free     = !rsp_valid_ff || !rsp_stall;
      // hold the scan when a held expiry has nowhere to go
      scan_advance = !(cur_fire && pend_valid_ff && !out_free);
      rsp_load     = pend_valid_ff && out_free &&
                     (((state_ff == S_TICK_SCAN) && cur_fire) || (state_ff == S_FLUSH));
      do_insert    = (state_ff == S_INSERT) && !matched_ff && !delay_zero && free_found_ff;
      prog_busy    = (state_ff == S_PROG_SCAN) || (state_ff == S_INSERT);
      flush_exit   = (state_ff == S_FLUSH) && (!pend_valid_ff || out_free);

      wr_cfg     = 1'b0;
      wr_cnt     = 1'b0;
      wr_idx     = scan_idx_ff;
      wr_cnt_val = req_ff.delay;
      case (state_ff)
         S_PROG_SCAN: begin
            if (cur_match && !delay_zero) begin
               wr_cfg = 1'b1;
               wr_cnt = 1'b1;
            end
         end
         S_INSERT: begin
            wr_idx = free_idx_ff;
            wr_cfg = do_insert;
            wr_cnt = do_insert;
         end
         S_TICK_SCAN: begin
            if (cur_active && scan_advance) begin
               if (cur_gt1) begin
                  wr_cnt     = 1'b1;
                  wr_cnt_val = cur_count - DELAY_W'(1);
               end else if (slot_repeats_ff[scan_idx_ff]) begin
                  wr_cnt     = 1'b1;
                  wr_cnt_val = slot_period_ff[scan_idx_ff];
               end
            end
         end
         default: begin
         end
      endcase
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (wr_cfg) begin
         slot_id_ff[wr_idx]      <= req_ff.msg_id;
         slot_repeats_ff[wr_idx] <= req_ff.periodic;
         slot_period_ff[wr_idx]  <= req_ff.delay;
      end
      if (wr_cnt) begin
         slot_count_ff[wr_idx] <= wr_cnt_val;
      end
   end

   // sequencer, valid bits and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         slot_active_ff <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         matched_ff     <= 1'b0;
         free_found_ff  <= 1'b0;
         scan_idx_ff    <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff        <= req_word;
                  scan_idx_ff   <= '0;
                  matched_ff    <= 1'b0;
                  free_found_ff <= 1'b0;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= (req_word.command == CMD_TICK) ? S_TICK_SCAN
                                                                  : S_PROG_SCAN;
               end
            end
            S_PROG_SCAN: begin
               if (cur_match) begin
                  matched_ff <= 1'b1;
                  if (delay_zero) begin
                     slot_active_ff[scan_idx_ff] <= 1'b0;
                  end
               end else if (!cur_active && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_idx_ff   <= scan_idx_ff;
               end
               if (scan_idx_ff == LAST_IDX) begin
                  state_ff <= S_INSERT;
               end else begin
                  scan_idx_ff <= scan_idx_ff + SLOT_IDX_W'(1);
               end
            end
            S_INSERT: begin
               if (do_insert) begin
                  slot_active_ff[free_idx_ff] <= 1'b1;
               end
               state_ff <= S_IDLE;
            end
            S_TICK_SCAN: begin
               if (scan_advance) begin
                  if (cur_fire) begin
                     if (pend_valid_ff) begin
                        rsp_word_ff.fired_id   <= pend_id_ff;
                        rsp_word_ff.last_fired <= 1'b0;
                     end
                     pend_valid_ff <= 1'b1;
                     pend_id_ff    <= slot_id_ff[scan_idx_ff];
                     if (!slot_repeats_ff[scan_idx_ff]) begin
                        slot_active_ff[scan_idx_ff] <= 1'b0;
                     end
                  end
                  if (scan_idx_ff == LAST_IDX) begin
                     state_ff <= S_FLUSH;
                  end else begin
                     scan_idx_ff <= scan_idx_ff + SLOT_IDX_W'(1);
                  end
               end
            end
            S_FLUSH: begin
               if (!pend_valid_ff) begin
                  state_ff <= S_IDLE;
               end else if (out_free) begin
                  rsp_word_ff.fired_id   <= pend_id_ff;
                  rsp_word_ff.last_fired <= 1'b1;
                  pend_valid_ff          <= 1'b0;
                  state_ff               <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // a program command never holds an expiry
   `ATT_ASSERT_NOW(a_prog_no_pending, prog_busy, !pend_valid_ff)
   // words enter the output register only from a held expiry
   `ATT_ASSERT_NOW(a_load_from_pending, rsp_load, pend_valid_ff && out_free)
   // the closing cycles return to idle once nothing is held
   `ATT_ASSERT_NEXT(a_insert_done, state_ff == S_INSERT, state_ff == S_IDLE)
   `ATT_ASSERT_NEXT(a_flush_done, flush_exit, (state_ff == S_IDLE) && !pend_valid_ff)

endmodule
